/* rtl/hrtl_pkg.sv */
// Shared types, constants and register codes of the HRPT time code lock.
`default_nettype none

package hrtl_pkg;

  localparam int unsigned TC_W      = 64;
  localparam int unsigned DAY_W     = 9;
  localparam int unsigned MS_W      = 27;
  localparam int unsigned SPACE_W   = 10;
  localparam int unsigned MATCH_W   = 4;
  localparam int unsigned LINE_IDX_W = 16;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned LINE_COUNT_BITS_DEF = 16;

  localparam logic [MS_W-1:0]  MS_PER_DAY = 27'd86400000;
  localparam logic [DAY_W-1:0] MAX_DAY    = 9'd366;

  localparam logic [SPACE_W-1:0] MIN_SPACING_RST = 10'd166;
  localparam logic [SPACE_W-1:0] MAX_SPACING_RST = 10'd167;
  localparam logic [MATCH_W-1:0] REQ_MATCH_RST   = 4'd5;
  localparam logic [DAY_W-1:0]   FALLBACK_RST    = 9'd1;

  localparam logic [6:0] MS_HI_MASK = 7'h7f;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SPACING = 8'd0,
    CFG_MAX_SPACING = 8'd1,
    CFG_REQ_MATCHES = 8'd2,
    CFG_FALLBACK    = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [SPACE_W-1:0] min_spacing;
    logic [SPACE_W-1:0] max_spacing;
    logic [MATCH_W-1:0] req_matches;
    logic [DAY_W-1:0]   fallback_day;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [DAY_W-1:0] day;
    logic [MS_W-1:0]  ms;
  } dec_t;

  typedef struct packed {
    logic                  spacing_ok;
    logic [MATCH_W-1:0]    match_count;
    logic                  locked;
    logic [LINE_IDX_W-1:0] line_index;
  } trk_t;

endpackage

`default_nettype wire

/* rtl/hrtl_if.sv */
// Channel interfaces: time code items, result items, register writes.
`default_nettype none

interface hrtl_in_if;
  logic                        valid;
  logic                        ready;
  logic [hrtl_pkg::TC_W-1:0]   time_code;
  logic                        pass_start;

  modport source (output valid, time_code, pass_start, input ready);
  modport sink   (input valid, time_code, pass_start, output ready);
endinterface

interface hrtl_out_if;
  logic                              valid;
  logic                              ready;
  logic [hrtl_pkg::DAY_W-1:0]        day_of_year;
  logic [hrtl_pkg::MS_W-1:0]         ms_of_day;
  logic                              code_valid;
  logic                              spacing_ok;
  logic [hrtl_pkg::MATCH_W-1:0]      match_count;
  logic                              locked;
  logic [hrtl_pkg::LINE_IDX_W-1:0]   line_index;

  modport source (output valid, day_of_year, ms_of_day, code_valid, spacing_ok,
                  match_count, locked, line_index, input ready);
  modport sink   (input valid, day_of_year, ms_of_day, code_valid, spacing_ok,
                  match_count, locked, line_index, output ready);
endinterface

interface hrtl_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [hrtl_pkg::CFG_IDX_W-1:0]    index;
  logic [hrtl_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/hrtl_cfg.sv */
// Configuration register file: window limits, lock count, fallback day.
`default_nettype none

module hrtl_cfg (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hrtl_cfg_if.sink    cfg_if,
  output hrtl_pkg::cfg_t cfg_o
);

  hrtl_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid) begin
      case (hrtl_pkg::cfg_idx_e'(cfg_if.index))
        hrtl_pkg::CFG_MIN_SPACING: cfg_d.min_spacing  = cfg_if.data[hrtl_pkg::SPACE_W-1:0];
        hrtl_pkg::CFG_MAX_SPACING: cfg_d.max_spacing  = cfg_if.data[hrtl_pkg::SPACE_W-1:0];
        hrtl_pkg::CFG_REQ_MATCHES: cfg_d.req_matches  = cfg_if.data[hrtl_pkg::MATCH_W-1:0];
        hrtl_pkg::CFG_FALLBACK:    cfg_d.fallback_day = cfg_if.data[hrtl_pkg::DAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_spacing  <= hrtl_pkg::MIN_SPACING_RST;
      cfg_q.max_spacing  <= hrtl_pkg::MAX_SPACING_RST;
      cfg_q.req_matches  <= hrtl_pkg::REQ_MATCH_RST;
      cfg_q.fallback_day <= hrtl_pkg::FALLBACK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/hrtl_decode.sv */
// Time code field extraction, range check and fallback day substitution.
`default_nettype none

module hrtl_decode (
  input  wire logic [hrtl_pkg::TC_W-1:0]  time_code_i,
  input  wire logic [hrtl_pkg::DAY_W-1:0] fallback_day_i,
  output hrtl_pkg::dec_t                  dec_o
);

  logic [7:0]  b0, b1, b3, b4, b5, b6, b7;
  logic [27:0] ms_raw;
  logic [14:0] day_raw;
  logic        in_range;

  assign b0 = time_code_i[63:56];
  assign b1 = time_code_i[55:48];
  assign b3 = time_code_i[39:32];
  assign b4 = time_code_i[31:24];
  assign b5 = time_code_i[23:16];
  assign b6 = time_code_i[15:8];
  assign b7 = time_code_i[7:0];

  // ms fields overlap, so this is a true sum, not a concatenation
  assign ms_raw = 28'({b3[6:0] & hrtl_pkg::MS_HI_MASK, 20'b0})
                + 28'({b4, b5, 10'b0})
                + 28'({b6, b7});
  assign day_raw  = {b0, b1[7:1]};
  assign in_range = (ms_raw <= 28'(hrtl_pkg::MS_PER_DAY));

  always_comb begin
    dec_o.valid = in_range;
    dec_o.day   = '0;
    dec_o.ms    = '0;
    if (in_range) begin
      // exactly one day's worth folds back to midnight
      dec_o.ms  = (ms_raw[hrtl_pkg::MS_W-1:0] == hrtl_pkg::MS_PER_DAY)
                  ? '0 : ms_raw[hrtl_pkg::MS_W-1:0];
      dec_o.day = (day_raw > 15'(hrtl_pkg::MAX_DAY))
                  ? fallback_day_i : day_raw[hrtl_pkg::DAY_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/hrtl_track.sv */
// Previous line time, spacing window check, match and line counters.
`default_nettype none

module hrtl_track #(
  parameter int unsigned LINE_COUNT_BITS = hrtl_pkg::LINE_COUNT_BITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic           pass_start_i,
  input  wire hrtl_pkg::dec_t dec_i,
  input  wire hrtl_pkg::cfg_t cfg_i,
  output hrtl_pkg::trk_t      trk_o
);

  localparam int unsigned STEP_W = hrtl_pkg::MS_W + 2;

  logic [hrtl_pkg::DAY_W-1:0]   prev_day_q, prev_day_d;
  logic [hrtl_pkg::MS_W-1:0]    prev_ms_q, prev_ms_d;
  logic                         prev_valid_q, prev_valid_d;
  logic [hrtl_pkg::MATCH_W-1:0] match_q, match_d;
  logic [LINE_COUNT_BITS-1:0]   line_q, line_d;

  logic                         prev_ok;
  logic                         same_day, next_day;
  logic [STEP_W-1:0]            step_ms;
  logic                         ok;
  logic [hrtl_pkg::MATCH_W-1:0] match_base;
  logic [LINE_COUNT_BITS-1:0]   line_base;

  assign prev_ok  = prev_valid_q && !pass_start_i;
  assign same_day = (dec_i.day == prev_day_q);
  assign next_day = ({1'b0, dec_i.day} == ({1'b0, prev_day_q} + 10'd1));

  // Both times are below one day, so only a step of zero or one day can
  // land in a 10-bit window; anything else is out of range or negative.
  assign step_ms = STEP_W'(dec_i.ms)
                 + (next_day ? STEP_W'(hrtl_pkg::MS_PER_DAY) : '0)
                 - STEP_W'(prev_ms_q);

  assign ok = dec_i.valid && prev_ok && (same_day || next_day)
           && !step_ms[STEP_W-1]
           && (step_ms >= STEP_W'(cfg_i.min_spacing))
           && (step_ms <= STEP_W'(cfg_i.max_spacing));

  assign match_base = pass_start_i ? '0 : match_q;
  assign line_base  = pass_start_i ? '0 : line_q;

  always_comb begin
    if (!ok) begin
      match_d = '0;
    end else if (match_base < cfg_i.req_matches) begin
      match_d = match_base + 4'd1;
    end else begin
      match_d = cfg_i.req_matches;
    end
  end

  always_comb begin
    line_d = (&line_base) ? line_base : line_base + LINE_COUNT_BITS'(1);
  end

  always_comb begin
    prev_day_d   = prev_day_q;
    prev_ms_d    = prev_ms_q;
    prev_valid_d = 1'b0;
    if (dec_i.valid) begin
      prev_day_d   = dec_i.day;
      prev_ms_d    = dec_i.ms;
      prev_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_day_q   <= '0;
      prev_ms_q    <= '0;
      prev_valid_q <= 1'b0;
      match_q      <= '0;
      line_q       <= '0;
    end else if (step_i) begin
      prev_day_q   <= prev_day_d;
      prev_ms_q    <= prev_ms_d;
      prev_valid_q <= prev_valid_d;
      match_q      <= match_d;
      line_q       <= line_d;
    end
  end

  assign trk_o.spacing_ok  = ok;
  assign trk_o.match_count = match_d;
  assign trk_o.locked      = (match_d >= cfg_i.req_matches);
  assign trk_o.line_index  = hrtl_pkg::LINE_IDX_W'(line_base);

endmodule

`default_nettype wire

/* rtl/hrpt_time_code_lock_top.sv */
// Top level of the HRPT time code lock: channels, pipeline registers, checks.
`default_nettype none

// Decodes the 8-byte time code of each HRPT scan line into day of year and
// milliseconds of day, flags codes above one day as invalid, and tracks lock:
// a valid line whose step from a valid previous line of the same pass falls
// inside [min_spacing_ms, max_spacing_ms] counts as a match, and locked rises
// once required_matches consecutive matches are seen. One result per item.
// Throughput is one item per clock while the output is not stalled; each item
// passes the input register, then the result register. The rate rests on
// hrtl_track updating its previous-time and counter registers as each line is
// processed, since every line reads and writes them. A result waiting on a
// stalled output keeps the input register full: the input takes one more
// transfer while that register is empty, then holds ready low until the output
// moves (in_if.ready follows out_if.ready combinationally). Register writes
// take effect at once and are meant to happen while no line is in flight.
module hrpt_time_code_lock_top #(
  parameter int unsigned LINE_COUNT_BITS = hrtl_pkg::LINE_COUNT_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hrtl_in_if.sink   in_if,
  hrtl_out_if.source out_if,
  hrtl_cfg_if.sink  cfg_if
);

  hrtl_pkg::cfg_t cfg;
  hrtl_pkg::dec_t dec;
  hrtl_pkg::trk_t trk;

  // input register stage
  logic                      s1_valid_q;
  logic [hrtl_pkg::TC_W-1:0] s1_tc_q;
  logic                      s1_start_q;

  // result register stage
  logic                            out_valid_q;
  logic [hrtl_pkg::DAY_W-1:0]      out_day_q;
  logic [hrtl_pkg::MS_W-1:0]       out_ms_q;
  logic                            out_code_valid_q;
  logic                            out_spacing_ok_q;
  logic [hrtl_pkg::MATCH_W-1:0]    out_match_q;
  logic                            out_locked_q;
  logic [hrtl_pkg::LINE_IDX_W-1:0] out_line_q;

  logic advance;   // result register can load this cycle
  logic proc;      // line in the input register is processed now
  logic in_xfer;

  assign advance     = !out_valid_q || out_if.ready;
  assign proc        = s1_valid_q && advance;
  assign in_if.ready = !s1_valid_q || advance;
  assign in_xfer     = in_if.valid && in_if.ready;

  hrtl_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  hrtl_decode u_decode (
    .time_code_i    (s1_tc_q),
    .fallback_day_i (cfg.fallback_day),
    .dec_o          (dec)
  );

  hrtl_track #(
    .LINE_COUNT_BITS (LINE_COUNT_BITS)
  ) u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (proc),
    .pass_start_i (s1_start_q),
    .dec_i        (dec),
    .cfg_i        (cfg),
    .trk_o        (trk)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_tc_q    <= in_if.time_code;
      s1_start_q <= in_if.pass_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_day_q        <= dec.day;
      out_ms_q         <= dec.ms;
      out_code_valid_q <= dec.valid;
      out_spacing_ok_q <= trk.spacing_ok;
      out_match_q      <= trk.match_count;
      out_locked_q     <= trk.locked;
      out_line_q       <= trk.line_index;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.day_of_year = out_day_q;
  assign out_if.ms_of_day   = out_ms_q;
  assign out_if.code_valid  = out_code_valid_q;
  assign out_if.spacing_ok  = out_spacing_ok_q;
  assign out_if.match_count = out_match_q;
  assign out_if.locked      = out_locked_q;
  assign out_if.line_index  = out_line_q;

`ifndef ASSERT_OFF
  // a processed line always lands in the result register
  a_proc_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_valid_q)
    else $error("processed line did not reach result register");

  // an invalid code reports zero time and no match
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !dec.valid) |=> (out_day_q == '0) && (out_ms_q == '0) && !out_spacing_ok_q)
    else $error("invalid code carried time or match");

  // a match needs a valid code
  a_match_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && trk.spacing_ok) |-> dec.valid)
    else $error("match flagged on invalid code");

  // folded milliseconds stay below one day
  a_ms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> (out_ms_q < hrtl_pkg::MS_PER_DAY))
    else $error("ms_of_day out of range");
`endif

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the HRPT time code lock: directed and random scan lines.
`timescale 1ns / 100ps

module testbench;
  import hrtl_pkg::*;

  // Time base and limits
  localparam longint          DAY_MS       = longint'(MS_PER_DAY);
  localparam longint unsigned LINE_TOP     = (64'd1 << LINE_COUNT_BITS_DEF) - 1;
  localparam int unsigned     SPACING_TOP  = (1 << SPACE_W) - 1;
  localparam int unsigned     MATCH_TOP    = (1 << MATCH_W) - 1;
  localparam int unsigned     DAY_CODE_TOP = (1 << DAY_W) - 1;
  localparam int unsigned     DAY_RAW_TOP  = 32767;      // 15-bit day field of the code
  localparam int unsigned     MS_RAW_TOP   = (1 << MS_W) - 1;
  localparam int unsigned     PIPE_LATENCY = 4;          // two register stages, with margin
  localparam int unsigned     HOLD_CYCLES  = 300;        // long output stall
  localparam int unsigned     QUIET_LIMIT  = 3000;       // cycles without any transfer
  localparam int unsigned     REPORT_LIMIT = 10;
  localparam int unsigned     RANDOM_LINES = 1000;

  // One decoded line, as seen on the result channel
  typedef struct packed {
    logic [DAY_W-1:0]      day_of_year;
    logic [MS_W-1:0]       ms_of_day;
    logic                  code_valid;
    logic                  spacing_ok;
    logic [MATCH_W-1:0]    match_count;
    logic                  locked;
    logic [LINE_IDX_W-1:0] line_index;
  } line_time_t;

  logic clk_i;
  logic rst_ni;

  hrtl_in_if  in_ch();
  hrtl_out_if out_ch();
  hrtl_cfg_if cfg_ch();

  hrpt_time_code_lock_top #(
    .LINE_COUNT_BITS(LINE_COUNT_BITS_DEF)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Predictor copy of the registers, starting at their reset values
  logic [SPACE_W-1:0] win_min      = MIN_SPACING_RST;
  logic [SPACE_W-1:0] win_max      = MAX_SPACING_RST;
  logic [MATCH_W-1:0] need_matches = REQ_MATCH_RST;
  logic [DAY_W-1:0]   subst_day    = FALLBACK_RST;

  // Predictor copy of the tracking state
  logic [DAY_W-1:0]   last_day    = '0;
  logic [MS_W-1:0]    last_ms     = '0;
  logic               last_valid  = 1'b0;
  logic [MATCH_W-1:0] run_matches = '0;
  longint unsigned    lines_seen  = 0;

  line_time_t expected_times[$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  // Idling controls: the sender's share is read only by the stimulus process,
  // the receiver's share by the receiver process, the burst flag by both.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        burst_mode    = 1'b0;
  logic        recv_hold     = 1'b0;
  event        stall_ev;

  // Stimulus-side notion of where the current pass is in time
  int     gen_day;
  longint gen_ms;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Decode one time code and update the lock tracking, as the block should.
  function automatic line_time_t predict_line_time(input logic [TC_W-1:0] code,
                                                   input logic start);
    line_time_t      r;
    longint unsigned ms_raw;
    int unsigned     day_raw;
    longint          step;
    logic            hit;
    r   = '0;
    hit = 1'b0;
    if (start) begin
      lines_seen  = 0;
      last_valid  = 1'b0;
      run_matches = '0;
    end
    // bytes 3..7 overlap on purpose; bit 7 of byte 3 is ignored
    ms_raw = (longint'(code[38:32]) << 20) + (longint'(code[31:16]) << 10)
           + longint'(code[15:0]);
    day_raw = 32'({code[63:56], code[55:49]});
    r.code_valid = (ms_raw <= DAY_MS);
    if (r.code_valid) begin
      if (ms_raw == DAY_MS) begin
        ms_raw = 0;
      end
      if (day_raw > MAX_DAY) begin
        day_raw = 32'(subst_day);
      end
      if (last_valid) begin
        // days are compared linearly, no year wrap
        step = (longint'(day_raw) - longint'(last_day)) * DAY_MS
             + longint'(ms_raw) - longint'(last_ms);
        hit = (step >= longint'(win_min)) && (step <= longint'(win_max));
      end
      last_day      = day_raw[DAY_W-1:0];
      last_ms       = ms_raw[MS_W-1:0];
      last_valid    = 1'b1;
      r.day_of_year = day_raw[DAY_W-1:0];
      r.ms_of_day   = ms_raw[MS_W-1:0];
    end else begin
      // stored time is kept, only its validity is dropped
      last_valid = 1'b0;
    end
    if (hit) begin
      run_matches = (run_matches < need_matches) ? run_matches + 1'b1 : need_matches;
    end else begin
      run_matches = '0;
    end
    r.spacing_ok  = hit;
    r.match_count = run_matches;
    r.locked      = (run_matches >= need_matches);
    r.line_index  = lines_seen[LINE_IDX_W-1:0];
    if (lines_seen < LINE_TOP) begin
      lines_seen++;
    end
    return r;
  endfunction

  // Build a code for a day and ms value. The ms value is split over bytes
  // 3..7 in a random one of its legal ways, and the unused bits are random.
  function automatic logic [TC_W-1:0] encode_time(input int unsigned day,
                                                  input int unsigned ms);
    logic [TC_W-1:0] c;
    int unsigned     lo_part;
    int unsigned     hi_part;
    int unsigned     k;
    int unsigned     j;
    int unsigned     b3v;
    int unsigned     b45;
    lo_part = ms & 1023;
    hi_part = ms >> 10;
    k       = $urandom_range(hi_part < 63 ? hi_part : 63);
    lo_part = lo_part + k * 1024;
    hi_part = hi_part - k;
    j       = $urandom_range((hi_part >> 10) < 63 ? (hi_part >> 10) : 63);
    b3v     = (hi_part >> 10) - j;
    b45     = (hi_part & 1023) + j * 1024;
    c[63:49] = day[14:0];
    c[48]    = 1'($urandom);
    c[47:40] = 8'($urandom);
    c[39]    = 1'($urandom);
    c[38:32] = b3v[6:0];
    c[31:16] = b45[15:0];
    c[15:0]  = lo_part[15:0];
    return c;
  endfunction

  // Receiver: random ready, overridden by bursts and by the long hold
  always @(posedge clk_i) begin
    out_ch.ready <= !recv_hold && (burst_mode || ($urandom_range(99) >= recv_idle_pct));
  end

  // Long hold on the result side, counted here so the sender keeps pushing
  initial forever begin
    @(stall_ev);
    recv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    recv_hold <= 1'b0;
  end

  // Scoreboard: track register writes, predict on each accepted line,
  // check each accepted result against the oldest prediction.
  always @(posedge clk_i) begin : scoreboard
    line_time_t got;
    line_time_t want;
    logic       moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        case (cfg_ch.index)
          CFG_MIN_SPACING: win_min      = cfg_ch.data[SPACE_W-1:0];
          CFG_MAX_SPACING: win_max      = cfg_ch.data[SPACE_W-1:0];
          CFG_REQ_MATCHES: need_matches = cfg_ch.data[MATCH_W-1:0];
          CFG_FALLBACK:    subst_day    = cfg_ch.data[DAY_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        moved           = 1'b1;
        got.day_of_year = out_ch.day_of_year;
        got.ms_of_day   = out_ch.ms_of_day;
        got.code_valid  = out_ch.code_valid;
        got.spacing_ok  = out_ch.spacing_ok;
        got.match_count = out_ch.match_count;
        got.locked      = out_ch.locked;
        got.line_index  = out_ch.line_index;
        if (expected_times.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("%0t: result with none pending: day %0d ms %0d line %0d",
                     $time, got.day_of_year, got.ms_of_day, got.line_index);
          end
          mismatches++;
        end else begin
          want = expected_times.pop_front();
          if (got !== want) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("%0t: expected day %0d ms %0d valid %0b ok %0b count %0d lock %0b line %0d",
                       $time, want.day_of_year, want.ms_of_day, want.code_valid,
                       want.spacing_ok, want.match_count, want.locked, want.line_index);
              $display("%0t:      got day %0d ms %0d valid %0b ok %0b count %0d lock %0b line %0d",
                       $time, got.day_of_year, got.ms_of_day, got.code_valid,
                       got.spacing_ok, got.match_count, got.locked, got.line_index);
            end
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        expected_times.push_back(predict_line_time(in_ch.time_code, in_ch.pass_start));
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog: a hung handshake ends the run
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one line; valid stays up afterwards unless the next call idles.
  task automatic send_line(input logic [TC_W-1:0] code, input logic start);
    while (!burst_mode && send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.time_code <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.time_code  <= code;
    in_ch.pass_start <= start;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Advance the pass clock by a signed step and send the resulting line
  task automatic send_step(input int step, input logic start);
    gen_ms = gen_ms + step;
    while (gen_ms >= DAY_MS) begin
      gen_ms = gen_ms - DAY_MS;
      gen_day++;
    end
    while (gen_ms < 0) begin
      gen_ms = gen_ms + DAY_MS;
      gen_day--;
    end
    if (gen_day < 0 || gen_day > DAY_RAW_TOP) begin
      gen_day = $urandom_range(MAX_DAY);
    end
    send_line(encode_time(gen_day, 32'(gen_ms)), start);
  endtask

  // Stop offering lines and wait until every result is back
  task automatic drain_lines;
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_times.size() != 0);
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  // One register transfer; the caller lowers valid after the last one
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] min_ms,
                           input logic [CFG_DATA_W-1:0] max_ms,
                           input logic [CFG_DATA_W-1:0] req,
                           input logic [CFG_DATA_W-1:0] fb_day);
    drain_lines();
    write_register(CFG_MIN_SPACING, min_ms);
    write_register(CFG_MAX_SPACING, max_ms);
    write_register(CFG_REQ_MATCHES, req);
    write_register(CFG_FALLBACK, fb_day);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure_random;
    int unsigned lo;
    int unsigned hi;
    int unsigned widen;
    case ($urandom_range(9))
      0: lo = 0;
      1: lo = SPACING_TOP;
      default: lo = $urandom_range(SPACING_TOP);
    endcase
    widen = $urandom_range(40);
    case ($urandom_range(9))
      0: hi = SPACING_TOP;
      1: hi = $urandom_range(SPACING_TOP);    // often an inverted window
      default: hi = (lo + widen > SPACING_TOP) ? SPACING_TOP : lo + widen;
    endcase
    configure(16'(lo), 16'(hi), 16'($urandom_range(MATCH_TOP)),
              16'($urandom_range(DAY_CODE_TOP)));
  endtask

  // One pass of scan lines: mostly in-window steps with random content,
  // mixed with off-window and backward steps, bad codes, the midnight fold
  // value and raw noise.
  task automatic send_pass(input int unsigned n_lines, input logic high_days);
    int unsigned i;
    int unsigned kind;
    logic        start;
    if (high_days || $urandom_range(9) == 0) begin
      gen_day = $urandom_range(DAY_RAW_TOP, MAX_DAY + 1);
    end else begin
      gen_day = $urandom_range(MAX_DAY);
    end
    if ($urandom_range(3) == 0) begin
      gen_ms = DAY_MS - $urandom_range(3000);    // start close to midnight
    end else begin
      gen_ms = $urandom_range(32'(DAY_MS - 1));
    end
    burst_mode <= ($urandom_range(3) == 0);
    for (i = 0; i < n_lines; i++) begin
      start = (i == 0) || ($urandom_range(49) == 0);
      kind  = $urandom_range(99);
      if (kind < 78) begin
        if (win_min <= win_max) begin
          send_step($urandom_range(win_max, win_min), start);
        end else begin
          send_step($urandom_range(1100), start);
        end
      end else if (kind < 86) begin
        send_step($urandom_range(2000), start);
      end else if (kind < 89) begin
        send_step(-int'($urandom_range(500)), start);
      end else if (kind < 93) begin
        send_line(encode_time(gen_day, $urandom_range(MS_RAW_TOP, 32'(DAY_MS + 1))), start);
      end else if (kind < 96) begin
        // one full day of ms folds to zero on the same day
        send_line(encode_time(gen_day, 32'(DAY_MS)), start);
        gen_ms = 0;
      end else begin
        send_line({$urandom, $urandom}, start);
      end
    end
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // Field extremes under the reset settings
  task automatic test_decode_extremes;
    send_line('0, 1'b1);                          // day 0, ms 0
    send_line('1, 1'b0);                          // day overflow, ms far above a day
    send_line(encode_time(32'(MAX_DAY), 32'(DAY_MS - 1)), 1'b0);
    send_line(encode_time(32'(MAX_DAY) + 1, 32'(DAY_MS)), 1'b0); // fallback day, ms folds
    send_line(encode_time(0, 32'(DAY_MS + 1)), 1'b0);             // first invalid ms
    send_line(encode_time(DAY_RAW_TOP, 0), 1'b0);                 // largest coded day
  endtask

  // Lock build-up across midnight, loss of lock, bad code, backward step,
  // and a pass start that forgets the previous time
  task automatic test_lock_sequence;
    int i;
    gen_day = 100;
    gen_ms  = DAY_MS - 1000;
    send_step(0, 1'b1);
    for (i = 0; i < 7; i++) begin
      send_step(166 + (i % 2), 1'b0);
    end
    send_step(165, 1'b0);                         // just under the window
    send_step(166, 1'b0);
    send_step(168, 1'b0);                         // just over it
    send_line(encode_time(gen_day, 32'(DAY_MS + 1)), 1'b0);
    send_step(166, 1'b0);                         // no valid previous line
    send_step(167, 1'b0);
    send_step(-166, 1'b0);
    send_step(166, 1'b1);
  endtask

  // Register corners: inverted window, zero and full match counts,
  // fallback day outside the calendar, stray index, unmasked write data
  task automatic test_register_corners;
    configure(16'(SPACING_TOP), 16'd0, 16'(REQ_MATCH_RST), 16'(FALLBACK_RST));
    send_pass(20, 1'b0);
    configure(16'd0, 16'(SPACING_TOP), 16'd0, 16'(MAX_DAY));
    send_pass(20, 1'b0);
    configure(16'(MIN_SPACING_RST), 16'(MAX_SPACING_RST), 16'(MATCH_TOP),
              16'(DAY_CODE_TOP));
    send_pass(40, 1'b1);
    configure(16'd0, 16'(SPACING_TOP), 16'd1, 16'd0);
    send_pass(20, 1'b1);
    drain_lines();
    write_register(8'($urandom_range((1 << CFG_IDX_W) - 1, CFG_FALLBACK + 1)),
                   16'($urandom));
    cfg_ch.valid <= 1'b0;
    configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    send_pass(20, 1'b0);
  endtask

  task automatic test_random_lines(input int unsigned n_lines);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_lines) begin
      len = ($urandom_range(4) == 0) ? $urandom_range(120, 40) : $urandom_range(30, 3);
      configure_random();
      send_pass(len, $urandom_range(7) == 0);
      sent = sent + len;
    end
  endtask

  // Result side held off for a long stretch while lines keep coming
  task automatic test_output_stall;
    int unsigned keep_pct;
    keep_pct      = send_idle_pct;
    send_idle_pct = 0;
    configure(16'(MIN_SPACING_RST), 16'(MAX_SPACING_RST), 16'(REQ_MATCH_RST),
              16'(FALLBACK_RST));
    -> stall_ev;
    send_pass(60, 1'b0);
    send_idle_pct = keep_pct;
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.time_code  <= '0;
    in_ch.pass_start <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender idles less than the receiver
    set_idling(26, 55);
    test_decode_extremes();
    test_lock_sequence();
    test_register_corners();
    test_random_lines(RANDOM_LINES / 3);

    // then the other way round
    set_idling(55, 26);
    test_output_stall();
    test_random_lines(RANDOM_LINES / 3);

    // full rate on both sides
    set_idling(0, 0);
    test_random_lines(RANDOM_LINES - 2 * (RANDOM_LINES / 3));

    drain_lines();
    if (mismatches == 0 && expected_times.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
